// File: sv/pip_pkg.sv
// Shared types, widths and codes for the point-in-polygon crossing-number block.
// Used by the controller, the datapath and the top level. No dependencies.
package pip_pkg;

   localparam int MAX_VERTICES  = 64;
   localparam int COORD_BITS    = 16;
   localparam int IDX_BITS      = $clog2(MAX_VERTICES);
   localparam int CNT_BITS      = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_BITS     = COORD_BITS + 2;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int KIND_BITS     = 2;
   localparam int CSR_ADDR_BITS = 1;

   typedef logic [KIND_BITS-1:0]             kind_type;
   typedef logic [CSR_ADDR_BITS-1:0]         csr_addr_type;
   typedef logic signed [COORD_BITS-1:0]     coord_type;
   typedef logic signed [DIFF_BITS-1:0]      diff_type;
   typedef logic signed [PROD_BITS-1:0]      prod_type;
   typedef logic [IDX_BITS-1:0]              idx_type;
   typedef logic [CNT_BITS-1:0]              cnt_type;

   localparam kind_type KIND_CLEAR  = 2'd0;
   localparam kind_type KIND_APPEND = 2'd1;
   localparam kind_type KIND_QUERY  = 2'd2;
   localparam kind_type KIND_SPARE  = 2'd3;

   localparam csr_addr_type CSR_ORIGIN_X = 1'b0;
   localparam csr_addr_type CSR_ORIGIN_Z = 1'b1;

   typedef struct packed {
      coord_type x;
      coord_type z;
   } vertex_type;

   typedef struct packed {
      logic    clear;
      logic    append;
      logic    load_point;
      logic    rd_en;
      logic    rd_edge;
      idx_type rd_addr;
   } cmd_type;

   typedef struct packed {
      cnt_type count;
      logic    full;
   } stat_type;

   function automatic diff_type to_diff(coord_type c);
      to_diff = {{(DIFF_BITS - COORD_BITS){c[COORD_BITS-1]}}, c};
   endfunction

endpackage

// File: sv/pip_ctrl.sv
// Controller state machine: decodes transfers, walks the vertex store, times the result.
// Depends on pip_pkg.
module pip_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  pip_pkg::kind_type  kind,
   input  pip_pkg::stat_type  stat,
   output pip_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import pip_pkg::*;

   localparam int DRAIN_CYCLES = 3;
   localparam int DRAIN_BITS   = $clog2(DRAIN_CYCLES);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic                   prime_ff, prime_in;
   idx_type                idx_ff, idx_in;
   logic [DRAIN_BITS-1:0]  drain_ff, drain_in;
   logic                   accept;
   cnt_type                cnt_m1;
   idx_type                last_idx;

   assign accept   = start && !busy;
   assign cnt_m1   = stat.count - 1'b1;
   assign last_idx = cnt_m1[IDX_BITS-1:0];
   assign busy     = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in = state_ff;
      prime_in = prime_ff;
      idx_in   = idx_ff;
      drain_in = drain_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind)
                  KIND_CLEAR:  cmd.clear = 1'b1;
                  KIND_APPEND: cmd.append = 1'b1;
                  KIND_QUERY: begin
                     cmd.load_point = 1'b1;
                     prime_in = 1'b1;
                     idx_in   = '0;
                     if (stat.count == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            cmd.rd_en = 1'b1;
            if (prime_ff) begin
               cmd.rd_addr = last_idx;
               prime_in    = 1'b0;
            end else begin
               cmd.rd_addr = idx_ff;
               cmd.rd_edge = 1'b1;
               if (idx_ff == last_idx) begin
                  state_in = ST_DRAIN;
                  drain_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_BITS'(DRAIN_CYCLES - 1)) begin
               state_in = ST_DONE;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prime_ff <= 1'b0;
         idx_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         prime_ff <= prime_in;
         idx_ff   <= idx_in;
         drain_ff <= drain_in;
      end
   end

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_empty_query: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == KIND_QUERY && stat.count == '0) |=> rsp_valid)
      else $error("query on an empty store did not answer at once");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (busy && !rsp_valid))
      else $error("vertex read outside of a query walk");

endmodule

// File: sv/pip_dpath.sv
// Datapath: origin registers, vertex store, and the pipelined edge crossing test.
// Depends on pip_pkg; driven by pip_ctrl commands.
module pip_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  pip_pkg::cmd_type      cmd,
   input  pip_pkg::coord_type    coord_x,
   input  pip_pkg::coord_type    coord_z,
   input  logic                  csr_we,
   input  pip_pkg::csr_addr_type csr_addr,
   input  pip_pkg::coord_type    csr_wdata,
   output pip_pkg::stat_type     stat,
   output logic                  parity
);
   import pip_pkg::*;

   vertex_type mem [MAX_VERTICES];

   coord_type  origin_x_ff, origin_z_ff;
   cnt_type    count_ff, count_in;
   logic       full;

   diff_type   px_ff, pz_ff;
   logic       rd_valid_ff, rd_edge_ff;
   vertex_type rd_vtx_ff, prev_ff;

   diff_type   xi, zi, dx_w, dz_w, a_w, e_w;
   logic       pos_w, neg_w, ok_w;

   logic       d_valid_ff, d_pos_ff;
   diff_type   dx_ff, dz_ff, a_ff, e_ff;

   logic       m_valid_ff, m_pos_ff;
   prod_type   p1_ff, p2_ff;
   logic       hit;
   logic       inside_ff;

   assign full       = (count_ff == CNT_BITS'(MAX_VERTICES));
   assign stat.count = count_ff;
   assign stat.full  = full;
   assign parity     = inside_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_z_ff <= '0;
         count_ff    <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
               CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !full) begin
         mem[count_ff[IDX_BITS-1:0]] <= '{x: coord_x, z: coord_z};
      end
      if (cmd.rd_en) begin
         rd_vtx_ff <= mem[cmd.rd_addr];
      end
   end

   assign xi   = to_diff(rd_vtx_ff.x);
   assign zi   = to_diff(rd_vtx_ff.z);
   assign dx_w = to_diff(prev_ff.x) - xi;
   assign dz_w = to_diff(prev_ff.z) - zi;
   assign a_w  = pz_ff - zi;
   assign e_w  = px_ff - xi;
   assign pos_w = !dz_w[DIFF_BITS-1] && (dz_w != '0);
   assign neg_w = dz_w[DIFF_BITS-1];

   always_comb begin
      ok_w = 1'b0;
      if (pos_w) begin
         ok_w = !a_w[DIFF_BITS-1] && (a_w < dz_w);
      end else if (neg_w) begin
         ok_w = (a_w[DIFF_BITS-1] || (a_w == '0)) && (a_w > dz_w);
      end
   end

   assign hit = m_pos_ff ? (p1_ff >= p2_ff) : (p2_ff >= p1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         rd_edge_ff  <= 1'b0;
         d_valid_ff  <= 1'b0;
         m_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
         rd_edge_ff  <= cmd.rd_en && cmd.rd_edge;
         d_valid_ff  <= rd_edge_ff && ok_w;
         m_valid_ff  <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         px_ff <= to_diff(coord_x) - to_diff(origin_x_ff);
         pz_ff <= to_diff(coord_z) - to_diff(origin_z_ff);
      end
      if (rd_valid_ff) begin
         prev_ff <= rd_vtx_ff;
      end
      dx_ff    <= dx_w;
      dz_ff    <= dz_w;
      a_ff     <= a_w;
      e_ff     <= e_w;
      d_pos_ff <= pos_w;
      p1_ff    <= dx_ff * a_ff;
      p2_ff    <= e_ff * dz_ff;
      m_pos_ff <= d_pos_ff;
      if (cmd.load_point) begin
         inside_ff <= 1'b0;
      end else if (m_valid_ff && hit) begin
         inside_ff <= !inside_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_VERTICES))
      else $error("vertex count beyond the store depth");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.append && !full && !cmd.clear) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted append did not advance the count");

   a_full_drops: assert property (@(posedge clock) disable iff (reset)
      (cmd.append && full) |=> $stable(count_ff))
      else $error("append to a full store changed the count");

endmodule

// File: sv/point_in_polygon_test_top.sv
// Top level of the point-in-polygon crossing-number block.
// Instantiates pip_ctrl and pip_dpath; depends on pip_pkg.
//
//   channel   ports                                       handshake
//   request   req_kind, req_coord_x, req_coord_z          start high and busy low
//   result    rsp_inside_res, rsp_vertices_held,          rsp_valid, one cycle
//             rsp_full_res
//   config    csr_addr, csr_wdata                         csr_we, no wait
//
// A clear or append transfer leaves the block idle, ready for the next transfer. A query
// over n stored vertices, n at least one, makes n + 1 vertex reads through the single
// store read port, drains the read, difference and product registers, shows the result
// and returns to idle. A query on an empty store answers in the next cycle.
// Reset is synchronous and empties the store and zeros both origins.
// The result is shown for one cycle only; the receiver cannot stall it.
module point_in_polygon_test_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pip_pkg::kind_type     req_kind,
   input  pip_pkg::coord_type    req_coord_x,
   input  pip_pkg::coord_type    req_coord_z,
   input  logic                  csr_we,
   input  pip_pkg::csr_addr_type csr_addr,
   input  pip_pkg::coord_type    csr_wdata,
   output logic                  rsp_valid,
   output logic                  rsp_inside_res,
   output pip_pkg::cnt_type      rsp_vertices_held,
   output logic                  rsp_full_res
);
   import pip_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     parity;

   pip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .kind      (req_kind),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pip_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .coord_x   (req_coord_x),
      .coord_z   (req_coord_z),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .parity    (parity)
   );

   assign rsp_inside_res    = parity;
   assign rsp_vertices_held = stat.count;
   assign rsp_full_res      = stat.full;

endmodule
